// ===== rtl/core/ucc_pkg.sv =====
// Constants, reciprocals and small lookup functions for the Unix time / civil date converter.
// Used by unix_time_civil_converter; no dependencies.
package ucc_pkg;

  typedef enum logic {
    FUNC_TO_SECONDS = 1'b0,
    FUNC_TO_CIVIL   = 1'b1
  } func_t;

  localparam int STAGES = 14;

  localparam int SEC_W       = 41;
  localparam int YEAR_IN_W   = 16;
  localparam int YEAR_OUT_W  = 17;

  localparam longint unsigned DAY_SECS_L    = 64'd86400;
  localparam longint unsigned ERA_DAYS_L    = 64'd146097;
  localparam longint unsigned EPOCH_SHIFT_L = 64'd719468;
  localparam longint unsigned CIV_ERA_BIAS  = 64'd82;
  localparam longint unsigned SEC_ERA_BIAS  = 64'd83;
  localparam longint unsigned DAY_BIAS_L    = ((64'd1 << 40) + DAY_SECS_L - 64'd1) / DAY_SECS_L;

  localparam logic [16:0] CIV_YEAR_BIAS = 17'(CIV_ERA_BIAS * 64'd400);
  localparam logic [25:0] CIV_DAY_OFF   = 26'(EPOCH_SHIFT_L + CIV_ERA_BIAS * ERA_DAYS_L);
  localparam logic [41:0] SEC_BIAS      = 42'(DAY_BIAS_L * DAY_SECS_L);
  localparam logic [24:0] ZP_OFF        = 25'(EPOCH_SHIFT_L + SEC_ERA_BIAS * ERA_DAYS_L
                                              - DAY_BIAS_L);
  localparam logic [16:0] SEC_YEAR_BIAS = 17'(SEC_ERA_BIAS * 64'd400);
  localparam logic signed [17:0] DAY_SECS_S = 18'sd86400;

  // ceil(2^k / d) reciprocals; k chosen so the quotient is exact over the operand range
  localparam logic [12:0] RECIP_25   = 13'(((64'd1 << 17) + 64'd24) / 64'd25);
  localparam logic [26:0] RECIP_675  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
  localparam logic [25:0] RECIP_ERA  = 26'(((64'd1 << 43) + ERA_DAYS_L - 64'd1) / ERA_DAYS_L);
  localparam logic [12:0] RECIP_225  = 13'(((64'd1 << 20) + 64'd224) / 64'd225);
  localparam logic [16:0] RECIP_365A = 17'(((64'd1 << 25) + 64'd364) / 64'd365);
  localparam logic [10:0] RECIP_15   = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
  localparam logic [18:0] RECIP_365B = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [11:0] RECIP_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  // (153 * mp + 2) / 5: days from March 1 to the start of March-based month mp
  function automatic logic [8:0] mp_days(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // yoe / 100 for yoe in 0..399
  function automatic logic [1:0] cent_of(input logic [8:0] yoe);
    return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
  endfunction

  // doe / 36524 for doe in 0..146096
  function automatic logic [2:0] quad_cent_of(input logic [17:0] doe);
    return 3'(doe >= 18'd36524) + 3'(doe >= 18'd73048) + 3'(doe >= 18'd109572)
         + 3'(doe >= 18'd146096);
  endfunction

endpackage

// ===== rtl/core/unix_time_civil_converter.sv =====
// Unix seconds <-> proleptic Gregorian UTC date/time converter, 14-stage pipeline.
// Depends on ucc_pkg.
// Throughput: one transaction per cycle while the output is not stalled; constant divisions
// are reciprocal multiplies or comparison lookups. Stalls collapse bubbles stage by stage.
// Reset clears the stage valid bits only; datapath registers are not reset.
module unix_time_civil_converter
  import ucc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic signed [SEC_W-1:0]       epoch_seconds_in,
  input  logic signed [YEAR_IN_W-1:0]   year_in,
  input  logic [3:0]                    month_in,
  input  logic [4:0]                    day_in,
  input  logic [4:0]                    hour_in,
  input  logic [5:0]                    minute_in,
  input  logic [5:0]                    second_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SEC_W-1:0]       epoch_seconds_out,
  output logic signed [YEAR_OUT_W-1:0]  year_out,
  output logic [3:0]                    month_out,
  output logic [4:0]                    day_out,
  output logic [4:0]                    hour_out,
  output logic [5:0]                    minute_out,
  output logic [5:0]                    second_out
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1
  logic        s1_civ;
  logic [16:0] s1_u0;
  logic [3:0]  s1_mp0;
  logic [4:0]  s1_day;
  logic [16:0] s1_hms;
  logic [18:0] s1_h;
  logic [15:0] s1_l;
  logic [6:0]  s1_lo7;
  logic [16:0] u0_c;
  logic [3:0]  mp0_c;
  logic [16:0] hms_c;
  logic [41:0] u1_c;

  assign u0_c  = 17'(year_in) + CIV_YEAR_BIAS - 17'(month_in <= 4'd2);
  assign mp0_c = (month_in > 4'd2) ? month_in - 4'd3 : month_in + 4'd9;
  assign hms_c = 17'(hour_in) * 17'd3600 + 17'(minute_in) * 17'd60 + 17'(second_in);
  assign u1_c  = 42'(epoch_seconds_in) + SEC_BIAS;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_civ <= (func == FUNC_TO_CIVIL);
      s1_u0  <= u0_c;
      s1_mp0 <= mp0_c;
      s1_day <= day_in;
      s1_hms <= hms_c;
      s1_h   <= u1_c[41:23];
      s1_l   <= u1_c[22:7];
      s1_lo7 <= u1_c[6:0];
    end
  end

  // stage 2
  logic              s2_civ;
  logic [16:0]       s2_u0;
  logic [7:0]        s2_q0;
  logic signed [9:0] s2_doy0;
  logic [16:0]       s2_hms;
  logic [18:0]       s2_h;
  logic [9:0]        s2_qh;
  logic [15:0]       s2_l;
  logic [6:0]        s2_lo7;
  logic [25:0]       p2_q0;
  logic [45:0]       p2_qh;
  logic [9:0]        doy0_c;

  assign p2_q0  = 26'(s1_u0[16:4]) * 26'(RECIP_25);
  assign p2_qh  = 46'(s1_h) * 46'(RECIP_675);
  assign doy0_c = 10'(mp_days(s1_mp0)) + 10'(s1_day) - 10'd1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_civ  <= s1_civ;
      s2_u0   <= s1_u0;
      s2_q0   <= p2_q0[24:17];
      s2_doy0 <= doy0_c;
      s2_hms  <= s1_hms;
      s2_h    <= s1_h;
      s2_qh   <= p2_qh[45:36];
      s2_l    <= s1_l;
      s2_lo7  <= s1_lo7;
    end
  end

  // stage 3
  logic              s3_civ;
  logic [7:0]        s3_q0;
  logic [8:0]        s3_yoe0;
  logic signed [9:0] s3_doy0;
  logic [16:0]       s3_hms;
  logic [9:0]        s3_qh;
  logic [25:0]       s3_nxt;
  logic [6:0]        s3_lo7;
  logic [16:0]       yoe0_c;
  logic [18:0]       rh_c;

  assign yoe0_c = s2_u0 - 17'(s2_q0) * 17'd400;
  assign rh_c   = s2_h - 19'(s2_qh) * 19'd675;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_civ  <= s2_civ;
      s3_q0   <= s2_q0;
      s3_yoe0 <= yoe0_c[8:0];
      s3_doy0 <= s2_doy0;
      s3_hms  <= s2_hms;
      s3_qh   <= s2_qh;
      s3_nxt  <= {rh_c[9:0], s2_l};
      s3_lo7  <= s2_lo7;
    end
  end

  // stage 4
  logic               s4_civ;
  logic [7:0]         s4_q0;
  logic signed [18:0] s4_doe0;
  logic [16:0]        s4_hms;
  logic [9:0]         s4_qh;
  logic [15:0]        s4_ql;
  logic [25:0]        s4_nxt;
  logic [6:0]         s4_lo7;
  logic [18:0]        doe0_c;
  logic [52:0]        p4_ql;

  assign doe0_c = 19'(s3_yoe0) * 19'd365 + 19'(s3_yoe0[8:2]) - 19'(cent_of(s3_yoe0))
                + 19'(s3_doy0);
  assign p4_ql  = 53'(s3_nxt) * 53'(RECIP_675);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_civ  <= s3_civ;
      s4_q0   <= s3_q0;
      s4_doe0 <= doe0_c;
      s4_hms  <= s3_hms;
      s4_qh   <= s3_qh;
      s4_ql   <= p4_ql[51:36];
      s4_nxt  <= s3_nxt;
      s4_lo7  <= s3_lo7;
    end
  end

  // stage 5
  logic               s5_civ;
  logic signed [25:0] s5_days;
  logic [16:0]        s5_hms;
  logic [24:0]        s5_zp;
  logic [16:0]        s5_rem;
  logic [25:0]        days_c;
  logic [25:0]        rl_c;

  assign days_c = 26'(s4_q0) * 26'd146097 + 26'(s4_doe0) - CIV_DAY_OFF;
  assign rl_c   = s4_nxt - 26'(s4_ql) * 26'd675;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_civ  <= s4_civ;
      s5_days <= days_c;
      s5_hms  <= s4_hms;
      s5_zp   <= 25'({s4_qh, s4_ql}) + ZP_OFF;
      s5_rem  <= {rl_c[9:0], s4_lo7};
    end
  end

  // stage 6
  logic               s6_civ;
  logic [40:0]        s6_secs;
  logic [16:0]        s6_hms;
  logic [24:0]        s6_zp;
  logic [7:0]         s6_ea;
  logic [16:0]        s6_rem;
  logic [4:0]         s6_hr;
  logic signed [43:0] p6_secs;
  logic [50:0]        p6_ea;
  logic [25:0]        p6_hr;

  assign p6_secs = 44'(s5_days) * 44'(DAY_SECS_S);
  assign p6_ea   = 51'(s5_zp) * 51'(RECIP_ERA);
  assign p6_hr   = 26'(s5_rem[16:4]) * 26'(RECIP_225);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_civ  <= s5_civ;
      s6_secs <= p6_secs[40:0];
      s6_hms  <= s5_hms;
      s6_zp   <= s5_zp;
      s6_ea   <= p6_ea[50:43];
      s6_rem  <= s5_rem;
      s6_hr   <= p6_hr[24:20];
    end
  end

  // stage 7
  logic        s7_civ;
  logic [40:0] s7_sec0;
  logic [17:0] s7_doe;
  logic [7:0]  s7_ea;
  logic [4:0]  s7_hr;
  logic [11:0] s7_rt;
  logic [24:0] doe_c;
  logic [16:0] rt_c;

  assign doe_c = s6_zp - 25'(s6_ea) * 25'd146097;
  assign rt_c  = s6_rem - 17'(s6_hr) * 17'd3600;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_civ  <= s6_civ;
      s7_sec0 <= s6_secs + 41'(s6_hms);
      s7_doe  <= doe_c[17:0];
      s7_ea   <= s6_ea;
      s7_hr   <= s6_hr;
      s7_rt   <= rt_c[11:0];
    end
  end

  // stage 8
  logic        s8_civ;
  logic [40:0] s8_sec0;
  logic [17:0] s8_doe;
  logic [6:0]  s8_a;
  logic [2:0]  s8_b;
  logic        s8_c;
  logic [7:0]  s8_ea;
  logic [4:0]  s8_hr;
  logic [11:0] s8_rt;
  logic [5:0]  s8_min;
  logic [32:0] p8_a;
  logic [20:0] p8_min;

  assign p8_a   = 33'(s7_doe[17:2]) * 33'(RECIP_365A);
  assign p8_min = 21'(s7_rt[11:2]) * 21'(RECIP_15);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_civ  <= s7_civ;
      s8_sec0 <= s7_sec0;
      s8_doe  <= s7_doe;
      s8_a    <= p8_a[31:25];
      s8_b    <= quad_cent_of(s7_doe);
      s8_c    <= (s7_doe == 18'd146096);
      s8_ea   <= s7_ea;
      s8_hr   <= s7_hr;
      s8_rt   <= s7_rt;
      s8_min  <= p8_min[19:14];
    end
  end

  // stage 9
  logic        s9_civ;
  logic [40:0] s9_sec0;
  logic [17:0] s9_doe;
  logic [17:0] s9_x;
  logic [7:0]  s9_ea;
  logic [4:0]  s9_hr;
  logic [5:0]  s9_min;
  logic [5:0]  s9_sec;
  logic [11:0] sec_c;

  assign sec_c = s8_rt - 12'(s8_min) * 12'd60;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_civ  <= s8_civ;
      s9_sec0 <= s8_sec0;
      s9_doe  <= s8_doe;
      s9_x    <= s8_doe - 18'(s8_a) + 18'(s8_b) - 18'(s8_c);
      s9_ea   <= s8_ea;
      s9_hr   <= s8_hr;
      s9_min  <= s8_min;
      s9_sec  <= sec_c[5:0];
    end
  end

  // stage 10
  logic        s10_civ;
  logic [40:0] s10_sec0;
  logic [17:0] s10_doe;
  logic [8:0]  s10_yoe;
  logic [7:0]  s10_ea;
  logic [4:0]  s10_hr;
  logic [5:0]  s10_min;
  logic [5:0]  s10_sec;
  logic [36:0] p10_yoe;

  assign p10_yoe = 37'(s9_x) * 37'(RECIP_365B);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_civ  <= s9_civ;
      s10_sec0 <= s9_sec0;
      s10_doe  <= s9_doe;
      s10_yoe  <= p10_yoe[35:27];
      s10_ea   <= s9_ea;
      s10_hr   <= s9_hr;
      s10_min  <= s9_min;
      s10_sec  <= s9_sec;
    end
  end

  // stage 11
  logic        s11_civ;
  logic [40:0] s11_sec0;
  logic [8:0]  s11_doy;
  logic [8:0]  s11_yoe;
  logic [7:0]  s11_ea;
  logic [4:0]  s11_hr;
  logic [5:0]  s11_min;
  logic [5:0]  s11_sec;
  logic [17:0] doy_c;

  assign doy_c = s10_doe - (18'(s10_yoe) * 18'd365 + 18'(s10_yoe[8:2])
                 - 18'(cent_of(s10_yoe)));

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s11_civ  <= s10_civ;
      s11_sec0 <= s10_sec0;
      s11_doy  <= doy_c[8:0];
      s11_yoe  <= s10_yoe;
      s11_ea   <= s10_ea;
      s11_hr   <= s10_hr;
      s11_min  <= s10_min;
      s11_sec  <= s10_sec;
    end
  end

  // stage 12
  logic        s12_civ;
  logic [40:0] s12_sec0;
  logic [10:0] s12_w;
  logic [8:0]  s12_doy;
  logic [8:0]  s12_yoe;
  logic [7:0]  s12_ea;
  logic [4:0]  s12_hr;
  logic [5:0]  s12_min;
  logic [5:0]  s12_sec;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s12_civ  <= s11_civ;
      s12_sec0 <= s11_sec0;
      s12_w    <= 11'(s11_doy) * 11'd5 + 11'd2;
      s12_doy  <= s11_doy;
      s12_yoe  <= s11_yoe;
      s12_ea   <= s11_ea;
      s12_hr   <= s11_hr;
      s12_min  <= s11_min;
      s12_sec  <= s11_sec;
    end
  end

  // stage 13
  logic        s13_civ;
  logic [40:0] s13_sec0;
  logic [3:0]  s13_mp;
  logic [8:0]  s13_doy;
  logic [8:0]  s13_yoe;
  logic [7:0]  s13_ea;
  logic [4:0]  s13_hr;
  logic [5:0]  s13_min;
  logic [5:0]  s13_sec;
  logic [22:0] p13_mp;

  assign p13_mp = 23'(s12_w) * 23'(RECIP_153);

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s13_civ  <= s12_civ;
      s13_sec0 <= s12_sec0;
      s13_mp   <= p13_mp[22:19];
      s13_doy  <= s12_doy;
      s13_yoe  <= s12_yoe;
      s13_ea   <= s12_ea;
      s13_hr   <= s12_hr;
      s13_min  <= s12_min;
      s13_sec  <= s12_sec;
    end
  end

  // stage 14: output register
  logic        s14_civ;
  logic [8:0]  dom_c;
  logic [3:0]  mon_c;
  logic [16:0] yr_c;

  assign dom_c = s13_doy - mp_days(s13_mp) + 9'd1;
  assign mon_c = (s13_mp < 4'd10) ? s13_mp + 4'd3 : s13_mp - 4'd9;
  assign yr_c  = 17'(s13_yoe) + 17'(s13_ea) * 17'd400 - SEC_YEAR_BIAS
               + 17'(mon_c <= 4'd2);

  always_ff @(posedge clk) begin
    if (en[13]) begin
      s14_civ <= s13_civ;
      if (s13_civ) begin
        epoch_seconds_out <= '0;
        year_out          <= yr_c;
        month_out         <= mon_c;
        day_out           <= dom_c[4:0];
        hour_out          <= s13_hr;
        minute_out        <= s13_min;
        second_out        <= s13_sec;
      end else begin
        epoch_seconds_out <= s13_sec0;
        year_out          <= '0;
        month_out         <= '0;
        day_out           <= '0;
        hour_out          <= '0;
        minute_out        <= '0;
        second_out        <= '0;
      end
    end
  end

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld))
    else $error("input blocked while a pipeline stage is empty");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && s14_civ |-> month_out >= 4'd1 && month_out <= 4'd12)
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && s14_civ |-> day_out >= 5'd1 && day_out <= 5'd31)
    else $error("day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && s14_civ |-> hour_out <= 5'd23 && minute_out <= 6'd59
                             && second_out <= 6'd59)
    else $error("time of day out of range");

endmodule
